/* rtl/core/timer_prescale_period_calc_macros.svh */
// timer_prescale_period_calc_macros.svh
// assertion macros shared by tppc_queue and tppc_back; each expects clk and rst_n in scope
// no other dependencies

`ifndef TIMER_PRESCALE_PERIOD_CALC_MACROS_SVH
`define TIMER_PRESCALE_PERIOD_CALC_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TPPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tppc_pkg.sv */
// tppc_pkg.sv
// shared types and constants for the timer prescale/period calculator
// no dependencies
`default_nettype none

package tppc_pkg;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_CLOCK_HZ = 2'd0;
    localparam logic [1:0]  CFG_MIN_FREQ = 2'd1;
    localparam logic [1:0]  CFG_MAX_FREQ = 2'd2;

    // reset values of the configuration registers
    localparam logic [31:0] CLOCK_HZ_RST = 32'd168000000;
    localparam logic [14:0] MIN_FREQ_RST = 15'd20;
    localparam logic [14:0] MAX_FREQ_RST = 15'd20000;

    // timer limits and prescaler codes
    localparam logic [15:0] PERIOD_MAX   = 16'd65535;
    localparam logic [9:0]  PRESCALE_NONE = 10'd0;
    localparam logic [9:0]  PRESCALE_MID = 10'd167;
    localparam logic [9:0]  PRESCALE_TOP = 10'd1023;

    // quotient limit: a quotient up to this gives a period that fits 16 bits
    localparam logic [31:0] QUOT_FIT     = 32'd65536;
    // clock/f below this gives a fitting period at prescale 167 (168 * 65537)
    localparam logic [31:0] MID_LIMIT    = 32'd11010216;
    // ceil(2^32 / 21): q/168 = ((q >> 3) * RECIP_21) >> 32, exact for q < 2^24
    localparam logic [27:0] RECIP_21     = 28'd204522253;

    // number of restoring division steps (one quotient bit each)
    localparam int          DIV_STAGES   = 32;

    // one queued request: clock and clamped, nonzero frequency
    typedef struct packed {
        logic [31:0] clk_hz;
        logic [14:0] freq;
    } tppc_entry_t;

    // one finished result
    typedef struct packed {
        logic        overflow;
        logic [14:0] compare;
        logic [15:0] period;
        logic [9:0]  prescale;
    } tppc_result_t;

endpackage

`default_nettype wire

/* rtl/core/tppc_front.sv */
// tppc_front.sv
// configuration registers and request clamping, feeds the request queue
// depends on tppc_pkg
`default_nettype none

module tppc_front
    import tppc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic [15:0]          freq_request,
    output tppc_entry_t               entry
);

    logic [31:0] clock_hz_reg;
    logic [14:0] min_freq_reg;
    logic [14:0] max_freq_reg;

    logic signed [16:0] req_ext;
    logic signed [16:0] lim_hi;
    logic signed [16:0] lim_lo;
    logic [14:0]        f_clamp;
    logic [30:0]        half_clk;
    logic [14:0]        f_half;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RST;
            min_freq_reg <= MIN_FREQ_RST;
            max_freq_reg <= MAX_FREQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLOCK_HZ: clock_hz_reg <= cfg_data;
                CFG_MIN_FREQ: min_freq_reg <= cfg_data[14:0];
                CFG_MAX_FREQ: max_freq_reg <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    // clamp to max, then min (min wins), then to half clock and at least one
    always_comb
    begin
        req_ext  = 17'(signed'(freq_request));
        lim_hi   = signed'({2'b00, max_freq_reg});
        lim_lo   = signed'({2'b00, min_freq_reg});
        if (req_ext > lim_hi)
        begin
            req_ext = lim_hi;
        end
        if (req_ext < lim_lo)
        begin
            req_ext = lim_lo;
        end
        f_clamp  = req_ext[14:0];
        half_clk = clock_hz_reg[31:1];
        if ({16'd0, f_clamp} > half_clk)
        begin
            f_half = half_clk[14:0];
        end
        else
        begin
            f_half = f_clamp;
        end
        if (f_half == 15'd0)
        begin
            f_half = 15'd1;
        end
    end

    assign entry.clk_hz = clock_hz_reg;
    assign entry.freq   = f_half;

endmodule

`default_nettype wire

/* rtl/core/tppc_queue.sv */
// tppc_queue.sv
// small fifo between the front and the back, lets each side stall alone
// depends on tppc_pkg and the macro header
`default_nettype none
`include "timer_prescale_period_calc_macros.svh"

module tppc_queue
    import tppc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  tppc_entry_t      push_data,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output tppc_entry_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    tppc_entry_t        mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != DEPTH_C);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // queue checks
    `TPPC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C, "queue count above depth")
    `TPPC_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count missed a push")
    `TPPC_ASSERT_NXT(a_count_down, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count missed a pop")

endmodule

`default_nettype wire

/* rtl/core/tppc_back.sv */
// tppc_back.sv
// pipelined restoring divider, prescaler selection and output register
// depends on tppc_pkg and the macro header
`default_nettype none
`include "timer_prescale_period_calc_macros.svh"

module tppc_back
    import tppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  tppc_entry_t      in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output tppc_result_t     out_data
);

    // divider stage registers, stage k holds k quotient bits
    logic        div_valid_reg [1:DIV_STAGES];
    logic [14:0] div_rem_reg   [1:DIV_STAGES];
    logic [31:0] div_work_reg  [1:DIV_STAGES];
    logic [14:0] div_den_reg   [1:DIV_STAGES];

    // reciprocal multiply stage
    logic        mul_valid_reg;
    logic [48:0] mul_prod_reg;
    logic [15:0] mul_p0_reg;
    logic        mul_sel0_reg;
    logic        mul_fit1_reg;
    logic [21:0] mul_q2_reg;

    // output register
    logic         out_valid_reg;
    tppc_result_t out_data_reg;

    logic         adv;
    logic [31:0]  q0;
    logic [31:0]  q0_dec;
    logic [16:0]  q1;
    logic [16:0]  q1_dec;
    logic [21:0]  q2_dec;
    tppc_result_t res_next;

    // the whole back advances together unless the output is stalled
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic        v_in;
        logic [14:0] r_in;
        logic [31:0] w_in;
        logic [14:0] d_in;
        logic [15:0] trial;
        logic [15:0] diff;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = 15'd0;
            assign w_in = in_data.clk_hz;
            assign d_in = in_data.freq;
        end
        else
        begin : g_rest
            assign v_in = div_valid_reg[k];
            assign r_in = div_rem_reg[k];
            assign w_in = div_work_reg[k];
            assign d_in = div_den_reg[k];
        end

        // trial subtract of the shifted remainder
        always_comb
        begin
            trial = {r_in, w_in[31]};
            diff  = trial - {1'b0, d_in};
            ge    = (trial >= {1'b0, d_in});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                div_valid_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[k+1]  <= ge ? diff[14:0] : trial[14:0];
                div_work_reg[k+1] <= {w_in[30:0], ge};
                div_den_reg[k+1]  <= d_in;
            end
        end
    end

    // unscaled period, range flags and clock/f/168 by reciprocal multiply
    assign q0     = div_work_reg[DIV_STAGES];
    assign q0_dec = q0 - 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= div_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_prod_reg <= 49'(q0[23:3]) * 49'(RECIP_21);
            mul_p0_reg   <= (q0 == 32'd0) ? 16'd0 : q0_dec[15:0];
            mul_sel0_reg <= (q0 <= QUOT_FIT);
            mul_fit1_reg <= (q0 < MID_LIMIT);
            mul_q2_reg   <= q0[31:10];
        end
    end

    // prescaler choice and saturation
    assign q1     = mul_prod_reg[48:32];
    assign q1_dec = q1 - 17'd1;
    assign q2_dec = mul_q2_reg - 22'd1;

    always_comb
    begin
        res_next = '0;
        if (mul_sel0_reg)
        begin
            res_next.prescale = PRESCALE_NONE;
            res_next.period   = mul_p0_reg;
        end
        else if (mul_fit1_reg)
        begin
            res_next.prescale = PRESCALE_MID;
            res_next.period   = q1_dec[15:0];
        end
        else if (mul_q2_reg <= 22'(QUOT_FIT))
        begin
            res_next.prescale = PRESCALE_TOP;
            res_next.period   = q2_dec[15:0];
        end
        else
        begin
            res_next.prescale = PRESCALE_TOP;
            res_next.period   = PERIOD_MAX;
            res_next.overflow = 1'b1;
        end
        res_next.compare = res_next.period[15:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // result and pipeline checks
    `TPPC_ASSERT_IMP(a_pre_code, out_valid_reg, (out_data_reg.prescale == PRESCALE_NONE) || (out_data_reg.prescale == PRESCALE_MID) || (out_data_reg.prescale == PRESCALE_TOP), "illegal prescale code")
    `TPPC_ASSERT_IMP(a_ovf_sat, out_valid_reg && out_data_reg.overflow, (out_data_reg.period == PERIOD_MAX) && (out_data_reg.prescale == PRESCALE_TOP), "overflow without saturation")
    `TPPC_ASSERT_NXT(a_tail_move, adv && div_valid_reg[DIV_STAGES], mul_valid_reg, "divider result lost")
    `TPPC_ASSERT_NXT(a_stall_hold, !adv, out_valid_reg && $stable(mul_valid_reg), "back moved while stalled")

endmodule

`default_nettype wire

/* rtl/core/timer_prescale_period_calc.sv */
// timer_prescale_period_calc.sv
// top level: front (config, clamp), request queue, back (divider, prescaler pick)
// depends on tppc_pkg, tppc_front, tppc_queue, tppc_back
//
//  channel   | dir | payload
//  ----------+-----+------------------------------------------------------
//  s_axis    | in  | tdata[15:0] freq_request
//  m_axis    | out | tdata[9:0] prescale, [25:10] period, [40:26] compare,
//            |     | [41] overflow
//  cfg       | in  | cfg_index 0 clock_hz, 1 min_freq, 2 max_freq
//
// one item per cycle sustained unless the output stalls; the queue head feeds
// the first of 32 divider stages, one quotient bit each, then one reciprocal
// multiply stage, then the output register
// reset clears the queue and all stage valid bits; no clearing pass
// a stalled output freezes the whole back; the queue of QUEUE_DEPTH items
// keeps s_tready high until it fills
`default_nettype none

module timer_prescale_period_calc
    import tppc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [15:0] freq_request
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata    // prescale, period, compare, overflow, pad
);

    tppc_entry_t  front_entry;
    tppc_entry_t  queue_entry;
    logic         queue_valid;
    logic         back_ready;
    tppc_result_t result;

    // config and clamping
    tppc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .freq_request (s_tdata),
        .entry        (front_entry)
    );

    // decoupling queue
    tppc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_data   (queue_entry)
    );

    // division and prescaler selection
    tppc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_data   (queue_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // pack result fields, lowest first, zero padded to six bytes
    assign m_tdata = {6'd0, result.overflow, result.compare, result.period, result.prescale};

endmodule

`default_nettype wire
